// File: src/frmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frmr_pkg: shared types and constants for the framed radio message receiver
// Sync bytes, frame phase codes and the result word carried between stages.
// ----------------------------------------------------------------------------
package frmr_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hEC;
	localparam logic [7:0] SYNC_SECOND = 8'hA1;

	// Frame phase, one code per header byte plus hunt and payload
	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_FLEET   = 3'd2,
		PH_CS_HI   = 3'd3,
		PH_CS_LO   = 3'd4,
		PH_CMD     = 3'd5,
		PH_LEN     = 3'd6,
		PH_PAYLOAD = 3'd7
	} phase_t;

	// One result word
	typedef struct packed {
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [7:0]  data_index;
		logic        frame_end;
		logic [7:0]  fleet;
		logic [15:0] call_sign;
		logic [7:0]  command;
		logic [7:0]  payload_length;
	} res_t;

endpackage
`default_nettype wire

// File: src/frmr_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frmr_parse: frame parser
// Holds the frame phase, header fields and payload count; builds the result
// word combinationally for each payload byte and for a zero length byte.
// ----------------------------------------------------------------------------
module frmr_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	output frmr_pkg::res_t     res,
	output logic               res_en
);
	import frmr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  fleet_q, fleet_d;
	logic [15:0] call_sign_q, call_sign_d;
	logic [7:0]  command_q, command_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  count_inc;

	assign count_inc = count_q + 8'd1;

	// Next state
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		fleet_d     = fleet_q;
		call_sign_d = call_sign_q;
		command_d   = command_q;
		length_d    = length_q;
		case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == SYNC_FIRST) phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				phase_d = (rx_byte == SYNC_SECOND) ? PH_FLEET : PH_HUNT1;
			end
			PH_FLEET: begin
				fleet_d = rx_byte;
				phase_d = PH_CS_HI;
			end
			PH_CS_HI: begin
				call_sign_d = {rx_byte, call_sign_q[7:0]};
				phase_d     = PH_CS_LO;
			end
			PH_CS_LO: begin
				call_sign_d = {call_sign_q[15:8], rx_byte};
				phase_d     = PH_CMD;
			end
			PH_CMD: begin
				command_d = rx_byte;
				phase_d   = PH_LEN;
			end
			PH_LEN: begin
				count_d = 8'd0;
				if (rx_byte == 8'd0) begin
					// empty frame ends here
					phase_d     = PH_HUNT1;
					fleet_d     = 8'd0;
					call_sign_d = 16'd0;
					command_d   = 8'd0;
					length_d    = 8'd0;
				end else begin
					length_d = rx_byte;
					phase_d  = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (count_inc >= length_q) begin
					phase_d     = PH_HUNT1;
					count_d     = 8'd0;
					fleet_d     = 8'd0;
					call_sign_d = 16'd0;
					command_d   = 8'd0;
					length_d    = 8'd0;
				end else begin
					count_d = count_inc;
				end
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	// Result word
	always_comb begin
		res_en             = 1'b0;
		res.data_valid     = 1'b0;
		res.data_byte      = 8'd0;
		res.data_index     = 8'd0;
		res.frame_end      = 1'b0;
		res.fleet          = fleet_q;
		res.call_sign      = call_sign_q;
		res.command        = command_q;
		res.payload_length = length_q;
		case (phase_q)
			PH_LEN: begin
				res.payload_length = rx_byte;
				if (rx_byte == 8'd0) begin
					res_en        = 1'b1;
					res.frame_end = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res_en         = 1'b1;
				res.data_valid = 1'b1;
				res.data_byte  = rx_byte;
				res.data_index = count_q;
				res.frame_end  = (count_inc >= length_q);
			end
			default: begin
				res_en = 1'b0;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT1;
			count_q     <= 8'd0;
			fleet_q     <= 8'd0;
			call_sign_q <= 16'd0;
			command_q   <= 8'd0;
			length_q    <= 8'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			fleet_q     <= fleet_d;
			call_sign_q <= call_sign_d;
			command_q   <= command_d;
			length_q    <= length_d;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_en && res.frame_end |=> phase_q == PH_HUNT1 && count_q == 8'd0
			&& length_q == 8'd0)
		else $error("frame end did not return parser to hunt");
	a_data_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_en && res.data_valid |-> phase_q == PH_PAYLOAD)
		else $error("payload word outside payload phase");
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_PAYLOAD |-> count_q == 8'd0)
		else $error("payload count nonzero outside payload phase");
`endif

endmodule
`default_nettype wire

// File: src/frmr_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frmr_outbuf: result register with skid stage
// Holds result words for the consumer; the skid entry lets the input side
// take a byte in the cycle the output stalls.
// ----------------------------------------------------------------------------
module frmr_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  frmr_pkg::res_t      push_res,
	output logic                ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output frmr_pkg::res_t      out_res
);
	import frmr_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_res_q, skid_res_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign ready     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Data
	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= skid_valid_q ? skid_res_q : push_res;
		end else if (!out_valid_q) begin
			out_res_q <= push_res;
		end else if (push) begin
			skid_res_q <= push_res;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("word pushed into full buffer");
	a_skid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> out_valid_q && !skid_valid_q)
		else $error("skid entry not forwarded on pop");
`endif

endmodule
`default_nettype wire

// File: src/framed_radio_message_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_radio_message_receiver: sync-word, length-prefixed frame receiver
// Hunts for sync 0xEC 0xA1, captures a five-byte header and streams the
// payload bytes out with their index and the header fields.
// ----------------------------------------------------------------------------
//   channel | handshake            | words
//   in      | in_valid / in_ready  | rx_byte
//   out     | out_valid / out_ready| data_valid data_byte data_index frame_end
//           |                      | fleet call_sign command payload_length
//
// One byte is taken per cycle while in_ready is high. Sync and header bytes
// produce no word but for a zero length byte, which ends an empty frame.
// A result word is registered in the output register, or in a skid entry
// behind it if the output stalls; in_ready drops only while both are full.
// Reset returns the parser to the sync hunt with cleared header fields.
// ----------------------------------------------------------------------------
module framed_radio_message_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             data_valid,
	output logic [7:0]       data_byte,
	output logic [7:0]       data_index,
	output logic             frame_end,
	output logic [7:0]       fleet,
	output logic [15:0]      call_sign,
	output logic [7:0]       command,
	output logic [7:0]       payload_length
);
	import frmr_pkg::*;

	logic accept;
	logic res_en;
	res_t res, out_res;

	assign accept = in_valid && in_ready;

	frmr_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_byte(rx_byte),
		.res    (res),
		.res_en (res_en)
	);

	frmr_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && res_en),
		.push_res (res),
		.ready    (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	// Unpack result word onto ports
	assign data_valid     = out_res.data_valid;
	assign data_byte      = out_res.data_byte;
	assign data_index     = out_res.data_index;
	assign frame_end      = out_res.frame_end;
	assign fleet          = out_res.fleet;
	assign call_sign      = out_res.call_sign;
	assign command        = out_res.command;
	assign payload_length = out_res.payload_length;

endmodule
`default_nettype wire

// File: bench/frmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frmr_checker: scoreboard for the framed radio message receiver
// Watches both channels. Each accepted input byte runs through a frame parser
// of its own. A result word it predicts is queued, and every word the receiver
// hands out is compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module frmr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        data_valid,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  data_index,
	input  wire logic        frame_end,
	input  wire logic [7:0]  fleet,
	input  wire logic [15:0] call_sign,
	input  wire logic [7:0]  command,
	input  wire logic [7:0]  payload_length,
	output int               fail_count,
	output int               pending,
	output int               words_checked,
	output int               frames_ended
);
	import frmr_pkg::*;

	// parser state, mirrors the receiver's frame registers
	phase_t      ph;
	logic [7:0]  count_q;
	logic [7:0]  fleet_q;
	logic [15:0] cs_q;
	logic [7:0]  cmd_q;
	logic [7:0]  len_q;

	res_t        frame_words_q[$];
	res_t        want;

	initial begin
		fail_count    = 0;
		pending       = 0;
		words_checked = 0;
		frames_ended  = 0;
	end

	task automatic clear_frame_state();
		ph      = PH_HUNT1;
		count_q = '0;
		fleet_q = '0;
		cs_q    = '0;
		cmd_q   = '0;
		len_q   = '0;
	endtask

	// advance the parser by one byte; queue the word it produces, if any
	task automatic parse_byte(input logic [7:0] b);
		res_t w;
		logic gives;
		w     = '0;
		gives = 1'b0;
		case (ph)
			PH_HUNT1: begin
				if (b == SYNC_FIRST)
					ph = PH_HUNT2;
			end
			// a wrong second byte goes back to the hunt, even another 0xEC
			PH_HUNT2: begin
				ph = (b == SYNC_SECOND) ? PH_FLEET : PH_HUNT1;
			end
			PH_FLEET: begin
				fleet_q = b;
				ph      = PH_CS_HI;
			end
			PH_CS_HI: begin
				cs_q[15:8] = b;
				ph         = PH_CS_LO;
			end
			PH_CS_LO: begin
				cs_q[7:0] = b;
				ph        = PH_CMD;
			end
			PH_CMD: begin
				cmd_q = b;
				ph    = PH_LEN;
			end
			// zero length ends the frame right at the length byte
			PH_LEN: begin
				len_q   = b;
				count_q = '0;
				if (b == 8'd0) begin
					w.frame_end = 1'b1;
					gives       = 1'b1;
				end else begin
					ph = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				w.data_valid = 1'b1;
				w.data_byte  = b;
				w.data_index = count_q;
				count_q      = count_q + 8'd1;
				w.frame_end  = (count_q >= len_q);
				gives        = 1'b1;
			end
			default: begin
				ph = PH_HUNT1;
			end
		endcase
		// every word carries the header captured so far
		if (gives) begin
			w.fleet          = fleet_q;
			w.call_sign      = cs_q;
			w.command        = cmd_q;
			w.payload_length = len_q;
			frame_words_q.push_back(w);
			if (w.frame_end)
				clear_frame_state();
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_val,
		input logic [15:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	// output side first: a word never comes out in the cycle its byte goes in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame_state();
			frame_words_q.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_words_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = frame_words_q.pop_front();
					check_field("data_valid", 16'(want.data_valid), 16'(data_valid));
					check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
					check_field("data_index", 16'(want.data_index), 16'(data_index));
					check_field("frame_end", 16'(want.frame_end), 16'(frame_end));
					check_field("fleet", 16'(want.fleet), 16'(fleet));
					check_field("call_sign", want.call_sign, call_sign);
					check_field("command", 16'(want.command), 16'(command));
					check_field("payload_length", 16'(want.payload_length),
						16'(payload_length));
					words_checked++;
					if (want.frame_end)
						frames_ended++;
				end
			end
			if (in_valid && in_ready)
				parse_byte(rx_byte);
			pending = frame_words_q.size();
		end
	end

endmodule

// File: bench/tb_framed_radio_message_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_radio_message_receiver: stimulus and verdict for the receiver
// Sends directed frames, then mostly well-formed random frames mixed with
// broken sync pairs and line noise, with random idling on both channels.
// Checking is done by frmr_checker sitting beside the receiver.
// ----------------------------------------------------------------------------
module tb_framed_radio_message_receiver;
	import frmr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_TARGET = 1350;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic [7:0]  data_index;
	logic        frame_end;
	logic [7:0]  fleet;
	logic [15:0] call_sign;
	logic [7:0]  command;
	logic [7:0]  payload_length;

	int          fail_count;
	int          pending;
	int          words_checked;
	int          frames_ended;

	bit          in_fire;
	bit          out_fire;
	bit          idle_on;
	bit          long_sent;
	int          out_stall;
	int          bytes_counted;
	int          cycle_count;
	int          sel;
	int          plen;
	int          r;
	logic [7:0]  bad_second;

	framed_radio_message_receiver uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_valid     (data_valid),
		.data_byte      (data_byte),
		.data_index     (data_index),
		.frame_end      (frame_end),
		.fleet          (fleet),
		.call_sign      (call_sign),
		.command        (command),
		.payload_length (payload_length)
	);

	frmr_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_valid     (data_valid),
		.data_byte      (data_byte),
		.data_index     (data_index),
		.frame_end      (frame_end),
		.fleet          (fleet),
		.call_sign      (call_sign),
		.command        (command),
		.payload_length (payload_length),
		.fail_count     (fail_count),
		.pending        (pending),
		.words_checked  (words_checked),
		.frames_ended   (frames_ended)
	);

	always #6 clk = ~clk;

	// handshakes as seen at the rising edge, read back at the falling edge
	always @(posedge clk) begin
		in_fire  <= in_valid & in_ready;
		out_fire <= out_valid & out_ready;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver side: after each word, may hold ready low at random while idling is on
	always @(negedge clk) begin
		if (out_fire)
			out_stall = idle_on ? $urandom_range(0, 3) : 0;
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// header bytes lean on the extremes
	function automatic logic [7:0] pick_byte();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 8'h00;
		if (k == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// one word on the input channel; counts only bytes the parser acts on
	task automatic send_word(input logic [7:0] b, input bit counts);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(negedge clk); while (!in_fire);
		if (counts)
			bytes_counted++;
	endtask

	task automatic send_frame(input logic [7:0] f, input logic [15:0] cs,
		input logic [7:0] cmd, input int len);
		send_word(SYNC_FIRST, 1'b1);
		send_word(SYNC_SECOND, 1'b1);
		send_word(f, 1'b1);
		send_word(cs[15:8], 1'b1);
		send_word(cs[7:0], 1'b1);
		send_word(cmd, 1'b1);
		send_word(8'(len), 1'b1);
		for (int k = 0; k < len; k++)
			send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		rx_byte       = 8'h00;
		out_ready     = 1'b0;
		idle_on       = 1'b1;
		long_sent     = 1'b0;
		out_stall     = 0;
		bytes_counted = 0;
		cycle_count   = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: noise, 0xEC twice then 0xA1 (no sync), zero length with
		// an all-ones header, one-byte payload with an all-zero header,
		// and a wrong second sync byte
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(SYNC_FIRST, 1'b1);
		send_word(SYNC_FIRST, 1'b1);
		send_word(SYNC_SECOND, 1'b0);
		send_frame(8'hFF, 16'hFFFF, 8'hFF, 0);
		send_frame(8'h00, 16'h0000, 8'h00, 1);
		send_word(SYNC_FIRST, 1'b1);
		send_word(8'h12, 1'b1);

		// let the receiver drain completely before the random part
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		// random: mostly good frames, some broken sync pairs, some noise
		while (bytes_counted < BYTE_TARGET) begin
			idle_on = ($urandom_range(0, 4) != 0);
			sel     = $urandom_range(0, 99);
			if (sel < 75) begin
				if (!long_sent && frames_ended >= 8) begin
					plen      = 255;
					long_sent = 1'b1;
				end else begin
					r = $urandom_range(0, 19);
					if (r == 0)
						plen = 0;
					else if (r == 1)
						plen = $urandom_range(13, 64);
					else
						plen = $urandom_range(1, 12);
				end
				send_frame(pick_byte(), {pick_byte(), pick_byte()}, pick_byte(), plen);
			end else if (sel < 88) begin
				bad_second = 8'($urandom_range(0, 255));
				if (bad_second == SYNC_SECOND || $urandom_range(0, 3) == 0)
					bad_second = SYNC_FIRST;
				send_word(SYNC_FIRST, 1'b1);
				send_word(bad_second, 1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(8'($urandom_range(0, 255)), 1'b0);
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d parsed bytes plus noise; %0d result words checked, %0d frames ended.",
			bytes_counted, words_checked, frames_ended);
		$display("Included zero, one and 255 byte payloads, bad sync pairs and random idling.");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
